// ===== sv/drfp_pkg.sv =====
// ============================================================================
// drfp_pkg
// Types and constants shared by the damage region frame pacer modules.
// ============================================================================
package drfp_pkg;

    localparam int CFG_BITS       = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int FRAME_CNT_BITS = 32;

    localparam logic [CFG_BITS-1:0] FRAME_INTERVAL_RST = 16'd8333;
    localparam logic [CFG_BITS-1:0] MIN_DELAY_RST      = 16'd100;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_INTERVAL   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MIN_DELAY  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_CONTINUOUS = 2'd2;

    typedef enum logic [1:0] {
        ACT_DAMAGE   = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_RENDER   = 2'd2,
        ACT_SCHEDULE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        EVT_NONE     = 2'd0,
        EVT_DUE      = 2'd1,
        EVT_RENDERED = 2'd2,
        EVT_SKIPPED  = 2'd3
    } event_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] frame_interval;
        logic [CFG_BITS-1:0] min_delay;
        logic                continuous_mode;
    } cfg_t;

endpackage

// ===== sv/drfp_core.sv =====
// ============================================================================
// drfp_core
// Damage box, frame timer and frame counter state with the per-request step.
// ============================================================================
module drfp_core
    import drfp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int TIMER_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  cfg_t                      cfg,
    input  action_t                   action,
    input  logic [COORD_BITS-1:0]     rect_x,
    input  logic [COORD_BITS-1:0]     rect_y,
    input  logic [COORD_BITS-2:0]     rect_w,
    input  logic [COORD_BITS-2:0]     rect_h,
    output event_t                    res_event,
    output logic [COORD_BITS-1:0]     res_box_x,
    output logic [COORD_BITS-1:0]     res_box_y,
    output logic [COORD_BITS:0]       res_box_w,
    output logic [COORD_BITS:0]       res_box_h,
    output logic                      res_pending,
    output logic                      res_scheduled,
    output logic [FRAME_CNT_BITS-1:0] res_frames
);

    localparam int EW = COORD_BITS + 3;
    localparam int DW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [COORD_BITS-1:0]     acc_x_reg, acc_x_next;
    logic [COORD_BITS-1:0]     acc_y_reg, acc_y_next;
    logic [COORD_BITS:0]       acc_w_reg, acc_w_next;
    logic [COORD_BITS:0]       acc_h_reg, acc_h_next;
    logic                      damage_reg, damage_next;
    logic                      armed_reg, armed_next;
    logic [TIMER_BITS-1:0]     countdown_reg, countdown_next;
    logic [TIMER_BITS-1:0]     since_reg, since_next;
    logic [FRAME_CNT_BITS-1:0] frames_reg, frames_next;

    logic signed [EW-1:0] old_l, old_t, new_l, new_t;
    logic signed [EW-1:0] old_r, old_b, new_r, new_b;
    logic signed [EW-1:0] u_l, u_t, u_r, u_b, u_w, u_h;
    logic                 rect_empty;

    logic [DW-1:0]         since_ext, interval_ext, delay_raw;
    logic [TIMER_BITS-1:0] since_tick;
    logic [TIMER_BITS-1:0] sched_delay;
    logic                  sched_ok;

    // box union
    always_comb begin
        old_l = {{3{acc_x_reg[COORD_BITS-1]}}, acc_x_reg};
        old_t = {{3{acc_y_reg[COORD_BITS-1]}}, acc_y_reg};
        new_l = {{3{rect_x[COORD_BITS-1]}}, rect_x};
        new_t = {{3{rect_y[COORD_BITS-1]}}, rect_y};
        old_r = old_l + {2'b00, acc_w_reg};
        old_b = old_t + {2'b00, acc_h_reg};
        new_r = new_l + {4'b0000, rect_w};
        new_b = new_t + {4'b0000, rect_h};
        u_l   = (old_l < new_l) ? old_l : new_l;
        u_t   = (old_t < new_t) ? old_t : new_t;
        u_r   = (old_r > new_r) ? old_r : new_r;
        u_b   = (old_b > new_b) ? old_b : new_b;
        u_w   = u_r - u_l;
        u_h   = u_b - u_t;
        rect_empty = (rect_w == '0) || (rect_h == '0);
    end

    // arming delay: the frame interval in continuous mode, else taken from the elapsed time including this tick
    always_comb begin
        since_tick = since_reg;
        if ((action == ACT_TICK) && (since_reg != TIMER_MAX)) begin
            since_tick = since_reg + 1'b1;
        end
        since_ext    = DW'(since_tick);
        interval_ext = DW'(cfg.frame_interval);
        if (cfg.continuous_mode) begin
            delay_raw = interval_ext;
        end else if (since_ext < interval_ext) begin
            delay_raw = interval_ext - since_ext;
        end else begin
            delay_raw = DW'(cfg.min_delay);
        end
        if (delay_raw > DW'(TIMER_MAX)) begin
            sched_delay = TIMER_MAX;
        end else begin
            sched_delay = delay_raw[TIMER_BITS-1:0];
        end
    end

    always_comb begin
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        acc_w_next     = acc_w_reg;
        acc_h_next     = acc_h_reg;
        damage_next    = damage_reg;
        armed_next     = armed_reg;
        countdown_next = countdown_reg;
        since_next     = since_reg;
        frames_next    = frames_reg;
        res_event      = EVT_NONE;
        res_box_x      = '0;
        res_box_y      = '0;
        res_box_w      = '0;
        res_box_h      = '0;
        sched_ok       = 1'b0;

        case (action)
            ACT_DAMAGE: begin
                if (!rect_empty) begin
                    damage_next = 1'b1;
                    if (!damage_reg) begin
                        acc_x_next = rect_x;
                        acc_y_next = rect_y;
                        acc_w_next = {2'b00, rect_w};
                        acc_h_next = {2'b00, rect_h};
                    end else begin
                        acc_x_next = u_l[COORD_BITS-1:0];
                        acc_y_next = u_t[COORD_BITS-1:0];
                        acc_w_next = u_w[COORD_BITS:0];
                        acc_h_next = u_h[COORD_BITS:0];
                    end
                end
            end
            ACT_TICK: begin
                since_next = since_tick;
                if (armed_reg) begin
                    if (countdown_reg <= TIMER_BITS'(1)) begin
                        countdown_next = '0;
                        armed_next     = 1'b0;
                        res_event      = EVT_DUE;
                        sched_ok       = !cfg.continuous_mode && damage_reg;
                    end else begin
                        countdown_next = countdown_reg - 1'b1;
                    end
                end
            end
            ACT_RENDER: begin
                if (!cfg.continuous_mode && !damage_reg) begin
                    res_event = EVT_SKIPPED;
                end else begin
                    res_event   = EVT_RENDERED;
                    res_box_x   = acc_x_reg;
                    res_box_y   = acc_y_reg;
                    res_box_w   = acc_w_reg;
                    res_box_h   = acc_h_reg;
                    acc_x_next  = '0;
                    acc_y_next  = '0;
                    acc_w_next  = '0;
                    acc_h_next  = '0;
                    damage_next = 1'b0;
                    frames_next = frames_reg + 1'b1;
                    since_next  = '0;
                    sched_ok    = cfg.continuous_mode && !armed_reg;
                end
            end
            ACT_SCHEDULE: begin
                sched_ok = !armed_reg && (cfg.continuous_mode || damage_reg);
            end
            default: begin
                res_event = EVT_NONE;
            end
        endcase

        if (sched_ok) begin
            armed_next     = 1'b1;
            countdown_next = sched_delay;
        end

        res_pending   = damage_next;
        res_scheduled = armed_next;
        res_frames    = frames_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_w_reg     <= '0;
            acc_h_reg     <= '0;
            damage_reg    <= 1'b0;
            armed_reg     <= 1'b0;
            countdown_reg <= '0;
            since_reg     <= '0;
            frames_reg    <= '0;
        end else if (step_en) begin
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            acc_w_reg     <= acc_w_next;
            acc_h_reg     <= acc_h_next;
            damage_reg    <= damage_next;
            armed_reg     <= armed_next;
            countdown_reg <= countdown_next;
            since_reg     <= since_next;
            frames_reg    <= frames_next;
        end
    end

endmodule

// ===== sv/damage_region_frame_pacer_unit.sv =====
// ============================================================================
// damage_region_frame_pacer_unit
// Damage bounding box accumulator with a tick-driven frame pacing timer.
// ============================================================================
//   channel   direction  handshake            content
//   s_        in         s_tvalid / s_tready  action, damage rectangle
//   m_        out        m_tvalid / m_tready  event, box, flags, frame count
//   cfg_      in         cfg_valid / cfg_ready register index and value
//
// one request per cycle while the output is not stalled; a request passes the input register, then the output register
// the box, timer and counter state update in the step between the input
// and output registers, so each request sees the previous one's effect
// a stalled result holds the input register; both stages fill before s_tready drops
// reset clears the valid flags and core state and loads the default frame interval and min delay
module damage_region_frame_pacer_unit
    import drfp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int TIMER_BITS = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // rect_x, rect_y, rect_w, rect_h, zero pad
    input  logic [((4*COORD_BITS-2+7)/8)*8-1:0]         s_tdata,
    // action
    input  logic [1:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // box_x, box_y, box_w, box_h, pending_flag, scheduled_flag, frames_done, zero pad
    output logic [((4*COORD_BITS+4+FRAME_CNT_BITS+7)/8)*8-1:0] m_tdata,
    // event_res
    output logic [1:0]                                  m_tuser,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]                     cfg_index,
    input  logic [CFG_BITS-1:0]                         cfg_data
);

    localparam int IN_BITS  = 4*COORD_BITS - 2;
    localparam int OUT_BITS = 4*COORD_BITS + 4 + FRAME_CNT_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    cfg_t cfg_reg;

    logic                  in_valid_reg;
    action_t               action_reg;
    logic [COORD_BITS-1:0] rect_x_reg, rect_y_reg;
    logic [COORD_BITS-2:0] rect_w_reg, rect_h_reg;

    logic                  out_valid_reg;
    event_t                event_reg;
    logic [OUT_BITS-1:0]   out_data_reg;

    logic                      out_free, step_en, in_take;
    event_t                    res_event;
    logic [COORD_BITS-1:0]     res_box_x, res_box_y;
    logic [COORD_BITS:0]       res_box_w, res_box_h;
    logic                      res_pending, res_scheduled;
    logic [FRAME_CNT_BITS-1:0] res_frames;

    assign out_free  = !out_valid_reg || m_tready;
    assign step_en   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = event_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_interval  <= FRAME_INTERVAL_RST;
            cfg_reg.min_delay       <= MIN_DELAY_RST;
            cfg_reg.continuous_mode <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_INTERVAL:   cfg_reg.frame_interval  <= cfg_data;
                CFG_IDX_MIN_DELAY:  cfg_reg.min_delay       <= cfg_data;
                CFG_IDX_CONTINUOUS: cfg_reg.continuous_mode <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            action_reg <= action_t'(s_tuser);
            rect_x_reg <= s_tdata[COORD_BITS-1:0];
            rect_y_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            rect_w_reg <= s_tdata[3*COORD_BITS-2:2*COORD_BITS];
            rect_h_reg <= s_tdata[IN_BITS-1:3*COORD_BITS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            event_reg    <= res_event;
            out_data_reg <= {res_frames, res_scheduled, res_pending,
                             res_box_h, res_box_w, res_box_y, res_box_x};
        end
    end

    drfp_core #(
        .COORD_BITS (COORD_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_en),
        .cfg           (cfg_reg),
        .action        (action_reg),
        .rect_x        (rect_x_reg),
        .rect_y        (rect_y_reg),
        .rect_w        (rect_w_reg),
        .rect_h        (rect_h_reg),
        .res_event     (res_event),
        .res_box_x     (res_box_x),
        .res_box_y     (res_box_y),
        .res_box_w     (res_box_w),
        .res_box_h     (res_box_h),
        .res_pending   (res_pending),
        .res_scheduled (res_scheduled),
        .res_frames    (res_frames)
    );

endmodule
